// File: hw/rtl/fgr_pkg.sv
// Package for the 5x7 font glyph rasterizer: cell geometry, glyph type and font ROM.
// Used by font_glyph_rasterizer; depends on nothing else.
`default_nettype none

package fgr_pkg;

	localparam int CELL_WIDTH  = 6;
	localparam int CELL_HEIGHT = 8;
	localparam int FONT_COLS   = 5;

	localparam int COL_W = $clog2(CELL_WIDTH);
	localparam int ROW_W = $clog2(CELL_HEIGHT);

	localparam logic [COL_W-1:0] LAST_COL = COL_W'(CELL_WIDTH - 1);
	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(CELL_HEIGHT - 1);

	localparam logic KIND_HEADER = 1'b0;
	localparam logic KIND_PIXEL  = 1'b1;

	// index 0 is the leftmost column, bit r of a column byte is row r
	typedef logic [0:FONT_COLS-1][7:0] glyph_t;

	localparam glyph_t GLYPH_UNKNOWN = 40'h0201510906;

	function automatic glyph_t font_lookup(input logic [7:0] code_in);
		logic [7:0] code;
		glyph_t     g;
		code = code_in;
		if (code >= 8'h61 && code <= 8'h7A) begin
			code = code - 8'h20;
		end
		case (code)
			8'h20: g = 40'h0000000000;
			8'h30: g = 40'h3E5149453E;
			8'h31: g = 40'h00427F4000;
			8'h32: g = 40'h4261514946;
			8'h33: g = 40'h2141454B31;
			8'h34: g = 40'h1814127F10;
			8'h35: g = 40'h2745454539;
			8'h36: g = 40'h3C4A494930;
			8'h37: g = 40'h0171090503;
			8'h38: g = 40'h3649494936;
			8'h39: g = 40'h064949291E;
			8'h41: g = 40'h7E1111117E;
			8'h42: g = 40'h7F49494936;
			8'h43: g = 40'h3E41414122;
			8'h44: g = 40'h7F4141221C;
			8'h45: g = 40'h7F49494941;
			8'h46: g = 40'h7F09090901;
			8'h47: g = 40'h3E4149497A;
			8'h48: g = 40'h7F0808087F;
			8'h49: g = 40'h00417F4100;
			8'h4A: g = 40'h2040413F01;
			8'h4B: g = 40'h7F08142241;
			8'h4C: g = 40'h7F40404040;
			8'h4D: g = 40'h7F020C027F;
			8'h4E: g = 40'h7F0408107F;
			8'h4F: g = 40'h3E4141413E;
			8'h50: g = 40'h7F09090906;
			8'h51: g = 40'h3E4151215E;
			8'h52: g = 40'h7F09192946;
			8'h53: g = 40'h4649494931;
			8'h54: g = 40'h01017F0101;
			8'h55: g = 40'h3F4040403F;
			8'h56: g = 40'h1F2040201F;
			8'h57: g = 40'h3F4038403F;
			8'h58: g = 40'h6314081463;
			8'h59: g = 40'h0708700807;
			8'h5A: g = 40'h6151494543;
			8'h2D: g = 40'h0808080808;
			8'h2E: g = 40'h0060600000;
			8'h3A: g = 40'h0036360000;
			8'h2F: g = 40'h2010080402;
			8'h25: g = 40'h6264081323;
			default: g = GLYPH_UNKNOWN;
		endcase
		return g;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/font_glyph_rasterizer.sv
// Top level of the 5x7 font glyph rasterizer: input stage, beat sequencer, result register.
// Depends on fgr_pkg for cell geometry and the font ROM.
`default_nettype none

// Each accepted character yields 49 output words: one window header (kind 0, cell from
// pos_x..pos_x+5 and pos_y..pos_y+7, no clipping, row end wraps mod 256) followed by 48
// pixel colors row by row, 6 per row, the sixth column always bg_color, last set on the
// 48th. One word leaves per cycle while out_stall is low; every word passes through the
// single result register. The next character is taken in the same cycle its predecessor's
// last pixel moves to the result register, so a steady stream with no output stall runs
// with no gap between characters. Lower case is drawn as upper case; codes without a
// glyph draw the unknown glyph.
module font_glyph_rasterizer
	import fgr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  char_code,
	input  wire logic [6:0]  pos_x,
	input  wire logic [7:0]  pos_y,
	input  wire logic [15:0] fg_color,
	input  wire logic [15:0] bg_color,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             kind,
	output logic [7:0]       col_start,
	output logic [7:0]       col_end,
	output logic [7:0]       row_start,
	output logic [7:0]       row_end,
	output logic [15:0]      pixel,
	output logic             last
);

	logic             s1_valid_s1;
	logic             hdr_s1;
	logic [COL_W-1:0] col_s1;
	logic [ROW_W-1:0] row_s1;
	glyph_t           glyph_s1;
	logic [15:0]      fg_s1;
	logic [15:0]      bg_s1;
	logic [6:0]       pos_x_s1;
	logic [7:0]       pos_y_s1;

	logic             out_valid_q;
	logic             kind_q;
	logic [7:0]       col_start_q;
	logic [7:0]       col_end_q;
	logic [7:0]       row_start_q;
	logic [7:0]       row_end_q;
	logic [15:0]      pixel_q;
	logic             last_q;

	logic             out_adv;
	logic             last_beat;
	logic             s1_done;
	logic             in_acc;
	logic             lit;

	always_comb begin
		out_adv   = !out_valid_q || !out_stall;
		last_beat = !hdr_s1 && col_s1 == LAST_COL && row_s1 == LAST_ROW;
		s1_done   = s1_valid_s1 && out_adv && last_beat;
		in_stall  = s1_valid_s1 && !s1_done;
		in_acc    = in_valid && !in_stall;
		lit       = 1'b0;
		if (col_s1 != LAST_COL) begin
			lit = glyph_s1[col_s1][row_s1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			hdr_s1      <= 1'b0;
			col_s1      <= '0;
			row_s1      <= '0;
		end else if (in_acc) begin
			s1_valid_s1 <= 1'b1;
			hdr_s1      <= 1'b1;
			col_s1      <= '0;
			row_s1      <= '0;
		end else if (s1_done) begin
			s1_valid_s1 <= 1'b0;
		end else if (s1_valid_s1 && out_adv) begin
			if (hdr_s1) begin
				hdr_s1 <= 1'b0;
			end else if (col_s1 == LAST_COL) begin
				col_s1 <= '0;
				row_s1 <= row_s1 + 1'b1;
			end else begin
				col_s1 <= col_s1 + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			glyph_s1 <= font_lookup(char_code);
			fg_s1    <= fg_color;
			bg_s1    <= bg_color;
			pos_x_s1 <= pos_x;
			pos_y_s1 <= pos_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= s1_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && s1_valid_s1) begin
			if (hdr_s1) begin
				kind_q      <= KIND_HEADER;
				col_start_q <= {1'b0, pos_x_s1};
				col_end_q   <= {1'b0, pos_x_s1} + 8'(CELL_WIDTH - 1);
				row_start_q <= pos_y_s1;
				row_end_q   <= pos_y_s1 + 8'(CELL_HEIGHT - 1);
				pixel_q     <= '0;
				last_q      <= 1'b0;
			end else begin
				kind_q      <= KIND_PIXEL;
				col_start_q <= '0;
				col_end_q   <= '0;
				row_start_q <= '0;
				row_end_q   <= '0;
				pixel_q     <= lit ? fg_s1 : bg_s1;
				last_q      <= last_beat;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign col_start = col_start_q;
	assign col_end   = col_end_q;
	assign row_start = row_start_q;
	assign row_end   = row_end_q;
	assign pixel     = pixel_q;
	assign last      = last_q;

	a_hdr_at_origin: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_s1 && hdr_s1 |-> col_s1 == '0 && row_s1 == '0)
		else $error("header beat away from cell origin");

	a_last_is_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> kind == KIND_PIXEL)
		else $error("last flag on a header word");

	a_header_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_HEADER |-> pixel == '0 && !last)
		else $error("header word carries pixel data");

	a_accept_frees: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> s1_valid_s1 && hdr_s1)
		else $error("accepted character not loaded as header beat");

endmodule

`default_nettype wire

// File: verif/fgr_checker.sv
`timescale 1ns / 100ps
// Checker for font_glyph_rasterizer: watches the character and pixel channels, predicts the
// window header and 48 pixel words of every accepted character and compares them in order.
// Depends on fgr_pkg for cell geometry, word kinds and the glyph column type.
module fgr_checker
	import fgr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  char_code,
	input  logic [6:0]  pos_x,
	input  logic [7:0]  pos_y,
	input  logic [15:0] fg_color,
	input  logic [15:0] bg_color,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        kind,
	input  logic [7:0]  col_start,
	input  logic [7:0]  col_end,
	input  logic [7:0]  row_start,
	input  logic [7:0]  row_end,
	input  logic [15:0] pixel,
	input  logic        last,
	output int          errors,
	output int          pending,
	output int          words_checked
);

	typedef struct packed {
		logic        kind;
		logic [7:0]  col_start;
		logic [7:0]  col_end;
		logic [7:0]  row_start;
		logic [7:0]  row_end;
		logic [15:0] pixel;
		logic        last;
	} cell_word_t;

	cell_word_t cell_words[$];
	cell_word_t oldest;
	glyph_t     font_rom [256];

	initial begin
		errors = 0;
		pending = 0;
		words_checked = 0;
		for (int k = 0; k < 256; k++) begin
			font_rom[k] = 40'h0201510906;
		end
		font_rom[8'h20] = 40'h0000000000;
		font_rom[8'h30] = 40'h3E5149453E;
		font_rom[8'h31] = 40'h00427F4000;
		font_rom[8'h32] = 40'h4261514946;
		font_rom[8'h33] = 40'h2141454B31;
		font_rom[8'h34] = 40'h1814127F10;
		font_rom[8'h35] = 40'h2745454539;
		font_rom[8'h36] = 40'h3C4A494930;
		font_rom[8'h37] = 40'h0171090503;
		font_rom[8'h38] = 40'h3649494936;
		font_rom[8'h39] = 40'h064949291E;
		font_rom[8'h41] = 40'h7E1111117E;
		font_rom[8'h42] = 40'h7F49494936;
		font_rom[8'h43] = 40'h3E41414122;
		font_rom[8'h44] = 40'h7F4141221C;
		font_rom[8'h45] = 40'h7F49494941;
		font_rom[8'h46] = 40'h7F09090901;
		font_rom[8'h47] = 40'h3E4149497A;
		font_rom[8'h48] = 40'h7F0808087F;
		font_rom[8'h49] = 40'h00417F4100;
		font_rom[8'h4A] = 40'h2040413F01;
		font_rom[8'h4B] = 40'h7F08142241;
		font_rom[8'h4C] = 40'h7F40404040;
		font_rom[8'h4D] = 40'h7F020C027F;
		font_rom[8'h4E] = 40'h7F0408107F;
		font_rom[8'h4F] = 40'h3E4141413E;
		font_rom[8'h50] = 40'h7F09090906;
		font_rom[8'h51] = 40'h3E4151215E;
		font_rom[8'h52] = 40'h7F09192946;
		font_rom[8'h53] = 40'h4649494931;
		font_rom[8'h54] = 40'h01017F0101;
		font_rom[8'h55] = 40'h3F4040403F;
		font_rom[8'h56] = 40'h1F2040201F;
		font_rom[8'h57] = 40'h3F4038403F;
		font_rom[8'h58] = 40'h6314081463;
		font_rom[8'h59] = 40'h0708700807;
		font_rom[8'h5A] = 40'h6151494543;
		font_rom[8'h2D] = 40'h0808080808;
		font_rom[8'h2E] = 40'h0060600000;
		font_rom[8'h3A] = 40'h0036360000;
		font_rom[8'h2F] = 40'h2010080402;
		font_rom[8'h25] = 40'h6264081323;
		// fold lower case onto upper case
		for (int k = 0; k < 26; k++) begin
			font_rom[8'h61 + k] = font_rom[8'h41 + k];
		end
	end

	task automatic report_mismatch(input string msg);
		$display("[%0t] fgr_checker: %s", $time, msg);
		errors++;
	endtask

	task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("word %0d: %s is %h, expected %h", words_checked, name,
				got, want));
		end
	endtask

	task automatic rasterize_cell(input logic [7:0] code, input logic [6:0] x,
		input logic [7:0] y, input logic [15:0] fg, input logic [15:0] bg);
		glyph_t     g;
		cell_word_t w;
		logic       lit;
		g = font_rom[code];
		w = '0;
		w.kind = KIND_HEADER;
		w.col_start = {1'b0, x};
		w.col_end = {1'b0, x} + 8'(CELL_WIDTH - 1);
		w.row_start = y;
		w.row_end = y + 8'(CELL_HEIGHT - 1);
		cell_words.push_back(w);
		for (int r = 0; r < CELL_HEIGHT; r++) begin
			for (int c = 0; c < CELL_WIDTH; c++) begin
				lit = (c < FONT_COLS) && g[c % FONT_COLS][r];
				w = '0;
				w.kind = KIND_PIXEL;
				w.pixel = lit ? fg : bg;
				w.last = (r == CELL_HEIGHT - 1) && (c == CELL_WIDTH - 1);
				cell_words.push_back(w);
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (cell_words.size() == 0) begin
					report_mismatch($sformatf("unexpected word: kind %b pixel %h last %b",
						kind, pixel, last));
				end else begin
					oldest = cell_words.pop_front();
					check_field("kind", 16'(kind), 16'(oldest.kind));
					check_field("col_start", 16'(col_start), 16'(oldest.col_start));
					check_field("col_end", 16'(col_end), 16'(oldest.col_end));
					check_field("row_start", 16'(row_start), 16'(oldest.row_start));
					check_field("row_end", 16'(row_end), 16'(oldest.row_end));
					check_field("pixel", pixel, oldest.pixel);
					check_field("last", 16'(last), 16'(oldest.last));
				end
				words_checked++;
			end
			if (in_valid && !in_stall) begin
				rasterize_cell(char_code, pos_x, pos_y, fg_color, bg_color);
			end
			pending = cell_words.size();
		end
	end

endmodule

// File: verif/tb_font_glyph_rasterizer.sv
`timescale 1ns / 100ps
// Testbench top for font_glyph_rasterizer: clock, reset, character stimulus, output stall
// pattern, watchdog and verdict. Depends on the block and on fgr_checker in verif.
module tb_font_glyph_rasterizer;

	localparam int QUIET_LIMIT     = 4000;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int DRAIN_CYCLES    = 60;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  char_code;
	logic [6:0]  pos_x;
	logic [7:0]  pos_y;
	logic [15:0] fg_color;
	logic [15:0] bg_color;
	logic        out_valid;
	logic        out_stall;
	logic        kind;
	logic [7:0]  col_start;
	logic [7:0]  col_end;
	logic [7:0]  row_start;
	logic [7:0]  row_end;
	logic [15:0] pixel;
	logic        last;

	int mismatches;
	int words_pending;
	int words_checked;
	int chars_sent;
	int quiet_cycles;
	int send_idle_pct;
	int recv_idle_pct;
	bit hold_off_req;

	font_glyph_rasterizer dut (.*);

	fgr_checker u_check (
		.*,
		.errors(mismatches),
		.pending(words_pending),
		.words_checked(words_checked)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [7:0] pick_code();
		string glyph_chars;
		glyph_chars = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz -.:/%";
		if ($urandom_range(3) == 0) begin
			return 8'($urandom_range(255));
		end
		return glyph_chars[$urandom_range(glyph_chars.len() - 1)];
	endfunction

	// enter and leave at a falling edge
	task automatic send_char(input logic [7:0] code, input logic [6:0] x, input logic [7:0] y,
		input logic [15:0] fg, input logic [15:0] bg);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		char_code = code;
		pos_x = x;
		pos_y = y;
		fg_color = fg;
		bg_color = bg;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		chars_sent++;
		@(negedge clk);
	endtask

	task automatic send_random(input int count);
		repeat (count) begin
			send_char(pick_code(), 7'($urandom_range(127)), 8'($urandom_range(159)),
				16'($urandom), 16'($urandom));
		end
	endtask

	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_stall = 1'b1;
				repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
			end else begin
				out_stall = ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Timeout: no word moved for %0d cycles, %0d words outstanding",
				QUIET_LIMIT, words_pending);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		string  directed;
		logic [7:0] odd_codes [5];
		logic [15:0] fg;
		arst_n = 1'b0;
		in_valid = 1'b0;
		char_code = '0;
		pos_x = '0;
		pos_y = '0;
		fg_color = '0;
		bg_color = '0;
		hold_off_req = 1'b0;
		chars_sent = 0;
		quiet_cycles = 0;
		send_idle_pct = 33;
		recv_idle_pct = 85;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// every glyph class, both ends of the ranges, codes next to the letter ranges
		directed = " 09AZaz-.:/%@[`{";
		foreach (directed[i]) begin
			fg = i[0] ? 16'hFFFF : 16'h0000;
			send_char(directed[i], i[0] ? 7'd127 : 7'd0, i[1] ? 8'd159 : 8'd0, fg, ~fg);
		end
		odd_codes = '{8'h00, 8'h1F, 8'h7F, 8'h80, 8'hFF};
		foreach (odd_codes[i]) begin
			send_char(odd_codes[i], 7'd123, 8'd153, 16'hA55A, 16'hA55A);
		end
		send_random(130);

		send_idle_pct = 85;
		recv_idle_pct = 33;
		send_random(130);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_off_req = 1'b1;
		send_random(140);

		in_valid = 1'b0;
		while (words_pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("Covered %0d characters (all glyph classes, unknown codes, window edges)",
			chars_sent);
		$display("over three traffic mixes and a %0d-cycle output hold-off; %0d words compared",
			HOLD_OFF_CYCLES, words_checked);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// File: font_glyph_rasterizer.f
hw/rtl/fgr_pkg.sv
hw/rtl/font_glyph_rasterizer.sv
verif/fgr_checker.sv
verif/tb_font_glyph_rasterizer.sv
